[sv/obstacle_appearance_tracker_defines.svh]
// Assertion macros for the obstacle appearance tracker.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef OBSTACLE_APPEARANCE_TRACKER_DEFINES_SVH
`define OBSTACLE_APPEARANCE_TRACKER_DEFINES_SVH

// Same-cycle implication, off during reset
`define OTA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define OTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ota_pkg.sv]
// Shared types and constants for the obstacle appearance tracker.
// No dependencies.
package ota_pkg;

    localparam int ID_FIELD_W  = 32;
    localparam int SEQ_W       = 32;
    localparam int COUNT_W     = 32;
    localparam int CFG_LIMIT_W = 8;
    localparam int CFG_AGE_W   = 16;
    localparam int OCC_W       = 8;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 56;

    localparam logic [CFG_LIMIT_W-1:0] MAX_ENTRIES_RST = 8'd100;
    localparam logic [CFG_LIMIT_W-1:0] CLEANUP_RST     = 8'd75;
    localparam logic [CFG_AGE_W-1:0]   KEEP_AGE_RST    = 16'd5;

    typedef enum logic [2:0] {
        ST_SKIPPED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_UPDATED    = 3'd2,
        ST_SAME_CYCLE = 3'd3,
        ST_DROPPED    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAX_ENTRIES = 2'd0,
        CFG_CLEANUP     = 2'd1,
        CFG_KEEP_AGE    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCAN  = 3'd1,
        S_APPLY = 3'd2,
        S_SWEEP = 3'd3,
        S_DONE  = 3'd4
    } ota_state_t;

endpackage

[sv/obstacle_appearance_tracker.sv]
// Obstacle appearance tracker: counts planning cycles in which each obstacle id is sighted.
// Flow: a skipped request goes straight to the output; others take the lookup walk, then the
// ageing walk when occupancy exceeds the cleanup level; the walks read one entry per cycle.
// Throughput: one request at a time, the next taken once the result is loaded into the output
// register, later while an earlier result waits on m_tready; config writes only when idle.
// Async reset: clears valid bits and occupancy, loads config defaults; entry data kept as is.
module obstacle_appearance_tracker
    import ota_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int ID_WIDTH    = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // obstacle_id[31:0], sequence_req[63:32], is_known_type[64], zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // is_skipped[0]
    input  logic [0:0]             s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // appear_count[31:0], ever_known[32], occupancy[40:33], removed[48:41], zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    // status[2:0]
    output logic [2:0]             m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [CFG_AGE_W-1:0]   cfg_data
);

    `include "obstacle_appearance_tracker_defines.svh"

    localparam int KEY_W   = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CFG_LIMIT_W) ? CNT_W : CFG_LIMIT_W;
    localparam int ENTRY_W = KEY_W + COUNT_W + SEQ_W + 1;
    localparam int CNT_LO  = KEY_W;
    localparam int SEQ_LO  = KEY_W + COUNT_W;
    localparam int KNW_BIT = KEY_W + COUNT_W + SEQ_W;

    // configuration
    logic [CFG_LIMIT_W-1:0] max_entries_reg;
    logic [CFG_LIMIT_W-1:0] cleanup_reg;
    logic [CFG_AGE_W-1:0]   keep_age_reg;

    // control
    ota_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       addr_reg, addr_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [CNT_W-1:0]       removed_reg, removed_next;
    logic                   hit_found_reg, hit_found_next;
    logic                   free_found_reg, free_found_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // payload
    logic [KEY_W-1:0]       id_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic                   known_reg;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0]     hit_count_reg, hit_count_next;
    logic [SEQ_W-1:0]       hit_seq_reg, hit_seq_next;
    logic                   hit_known_reg, hit_known_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    status_t                status_reg, status_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic                   kflag_reg, kflag_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [2:0]             m_tuser_reg, m_tuser_next;

    // entry RAM
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [KEY_W-1:0]       rd_id;
    logic [COUNT_W-1:0]     rd_count;
    logic [SEQ_W-1:0]       rd_seq;
    logic                   rd_known;
    logic [SEQ_W-1:0]       rd_age;
    logic                   rd_stale;
    logic                   in_accept;
    logic                   walk_end;
    logic                   do_insert;
    logic                   seq_differs;
    logic [COUNT_W-1:0]     count_inc;
    logic [CNT_W-1:0]       total_after;
    logic                   sweep_go;

    ota_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign in_accept = s_tvalid && s_tready;

    assign rd_id    = ram_rdata[KEY_W-1:0];
    assign rd_count = ram_rdata[CNT_LO +: COUNT_W];
    assign rd_seq   = ram_rdata[SEQ_LO +: SEQ_W];
    assign rd_known = ram_rdata[KNW_BIT];
    assign rd_age   = seq_reg - rd_seq;
    assign rd_stale = rd_age > {{(SEQ_W-CFG_AGE_W){1'b0}}, keep_age_reg};
    assign walk_end = (addr_reg == CNT_W'(TABLE_DEPTH)) && !chk_vld_reg;

    assign do_insert   = !hit_found_reg && free_found_reg &&
                         (CMP_W'(total_reg) < CMP_W'(max_entries_reg));
    assign seq_differs = (hit_seq_reg != seq_reg);
    assign count_inc   = (&hit_count_reg) ? hit_count_reg : hit_count_reg + COUNT_W'(1);
    assign total_after = do_insert ? total_reg + CNT_W'(1) : total_reg;
    assign sweep_go    = CMP_W'(total_after) > CMP_W'(cleanup_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
            cleanup_reg     <= CLEANUP_RST;
            keep_age_reg    <= KEEP_AGE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_data[CFG_LIMIT_W-1:0];
                CFG_CLEANUP:     cleanup_reg     <= cfg_data[CFG_LIMIT_W-1:0];
                CFG_KEEP_AGE:    keep_age_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            chk_vld_reg    <= 1'b0;
            valid_reg      <= '0;
            total_reg      <= '0;
            removed_reg    <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            chk_vld_reg    <= chk_vld_next;
            valid_reg      <= valid_next;
            total_reg      <= total_next;
            removed_reg    <= removed_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            id_reg    <= s_tdata[KEY_W-1:0];
            seq_reg   <= s_tdata[ID_FIELD_W +: SEQ_W];
            known_reg <= s_tdata[ID_FIELD_W + SEQ_W];
        end
        chk_idx_reg   <= chk_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        hit_seq_reg   <= hit_seq_next;
        hit_known_reg <= hit_known_next;
        free_idx_reg  <= free_idx_next;
        status_reg    <= status_next;
        cnt_reg       <= cnt_next;
        kflag_reg     <= kflag_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        valid_next      = valid_reg;
        total_next      = total_reg;
        removed_next    = removed_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        hit_seq_next    = hit_seq_reg;
        hit_known_next  = hit_known_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        kflag_next      = kflag_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg[IDX_W-1:0];

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // issue one read a cycle during either walk; data is checked in the next cycle
        if (state_reg == S_SCAN || state_reg == S_SWEEP)
        begin
            if (addr_reg != CNT_W'(TABLE_DEPTH))
            begin
                ram_re       = 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = addr_reg[IDX_W-1:0];
                addr_next    = addr_reg + CNT_W'(1);
            end
            else
            begin
                chk_vld_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    addr_next       = '0;
                    chk_vld_next    = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    if (s_tuser[0])
                    begin
                        status_next = ST_SKIPPED;
                        cnt_next    = '0;
                        kflag_next  = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg])
                    begin
                        if (!hit_found_reg && rd_id == id_reg)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                            hit_count_next = rd_count;
                            hit_seq_next   = rd_seq;
                            hit_known_next = rd_known;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                if (walk_end)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (hit_found_reg)
                begin
                    if (seq_differs)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = hit_idx_reg;
                        ram_wdata   = {hit_known_reg | known_reg, seq_reg, count_inc, id_reg};
                        status_next = ST_UPDATED;
                        cnt_next    = count_inc;
                        kflag_next  = hit_known_reg | known_reg;
                    end
                    else
                    begin
                        status_next = ST_SAME_CYCLE;
                        cnt_next    = hit_count_reg;
                        kflag_next  = hit_known_reg;
                    end
                end
                else if (do_insert)
                begin
                    ram_we                   = 1'b1;
                    ram_waddr                = free_idx_reg;
                    ram_wdata                = {known_reg, seq_reg, COUNT_W'(1), id_reg};
                    valid_next[free_idx_reg] = 1'b1;
                    total_next               = total_after;
                    status_next              = ST_INSERTED;
                    cnt_next                 = COUNT_W'(1);
                    kflag_next               = known_reg;
                end
                else
                begin
                    status_next = ST_DROPPED;
                    cnt_next    = '0;
                    kflag_next  = 1'b0;
                end
                addr_next    = '0;
                chk_vld_next = 1'b0;
                state_next   = sweep_go ? S_SWEEP : S_DONE;
            end
            S_SWEEP:
            begin
                // drop stale entries; at most one per cycle
                if (chk_vld_reg && valid_reg[chk_idx_reg] && rd_stale)
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                    total_next              = total_reg - CNT_W'(1);
                    removed_next            = removed_reg + CNT_W'(1);
                end
                if (walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output slot is free or being taken
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(M_TDATA_W - COUNT_W - 1 - 2*OCC_W)'(0),
                                     OCC_W'(removed_reg), OCC_W'(total_reg),
                                     kflag_reg, cnt_reg};
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `OTA_ASSERT_SAME(a_total_matches_valid, 1'b1,
        total_reg == CNT_W'($countones(valid_reg)), "occupancy out of step with valid bits")
    `OTA_ASSERT_NEXT(a_skip_goes_done, in_accept && s_tuser[0],
        state_reg == S_DONE && status_reg == ST_SKIPPED, "skipped request not answered at once")
    `OTA_ASSERT_NEXT(a_insert_grows, state_reg == S_APPLY && !hit_found_reg && do_insert,
        total_reg == $past(total_reg) + CNT_W'(1), "insert did not raise occupancy")

endmodule

[sv/ota_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ota_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[test/obstacle_appearance_tracker_test.sv]
// Self-checking testbench for obstacle_appearance_tracker: random and directed sightings
// are streamed in and each result is checked against a sighting table kept in the bench.
// Depends on ota_pkg and the obstacle_appearance_tracker RTL only.
`timescale 1ns / 100ps

module obstacle_appearance_tracker_test;
    import ota_pkg::*;

    localparam int TABLE_SLOTS  = 128;
    localparam int WATCHDOG_MAX = 5000;
    localparam int LONG_HOLD    = 600;

    typedef struct {
        logic [31:0] id;
        logic [31:0] seq;
        logic        known;
        logic        skip;
    } sighting_t;

    typedef struct {
        status_t     status;
        logic [31:0] count;
        logic        known;
        logic [7:0]  occ;
        logic [7:0]  removed;
    } sighting_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [CFG_AGE_W-1:0] cfg_data = '0;

    // Bench copy of the sighting table and registers
    logic        tbl_valid [TABLE_SLOTS];
    logic [31:0] tbl_id    [TABLE_SLOTS];
    logic [31:0] tbl_count [TABLE_SLOTS];
    logic [31:0] tbl_seq   [TABLE_SLOTS];
    logic        tbl_known [TABLE_SLOTS];
    int          tbl_total = 0;
    int          lim_entries = MAX_ENTRIES_RST;
    int          sweep_above = CLEANUP_RST;
    logic [31:0] stale_age = KEEP_AGE_RST;

    sighting_t        pending_q [$];
    sighting_result_t result_q [$];
    logic [31:0]      id_pool [$];
    logic [31:0]      fill_ids [$];
    logic [31:0]      plan_seq = 32'd0;

    int issued_n = 0;
    int accepted_n = 0;
    int pushed_n = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    int        burst_left = 0;
    int        gap_left = 0;
    int        gap_pick;
    sighting_t next_req;

    bit hold_req = 1'b0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    obstacle_appearance_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic sighting_result_t track_sighting(logic [31:0] id, logic [31:0] seq,
                                                        logic known, logic skip);
        sighting_result_t r;
        int               hit;
        int               free_slot;
        int               lim;
        int               n_removed;
        r.status  = ST_SKIPPED;
        r.count   = '0;
        r.known   = 1'b0;
        r.occ     = 8'(tbl_total);
        r.removed = '0;
        if (skip)
            return r;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (tbl_valid[i])
            begin
                if (hit < 0 && tbl_id[i] == id)
                    hit = i;
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        lim = (lim_entries < TABLE_SLOTS) ? lim_entries : TABLE_SLOTS;
        if (hit < 0)
        begin
            if (tbl_total < lim && free_slot >= 0)
            begin
                tbl_valid[free_slot] = 1'b1;
                tbl_id[free_slot]    = id;
                tbl_count[free_slot] = 32'd1;
                tbl_seq[free_slot]   = seq;
                tbl_known[free_slot] = known;
                tbl_total++;
                r.status = ST_INSERTED;
                r.count  = 32'd1;
                r.known  = known;
            end
            else
            begin
                r.status = ST_DROPPED;
            end
        end
        else
        begin
            if (tbl_seq[hit] != seq)
            begin
                if (tbl_count[hit] != 32'hFFFF_FFFF)
                    tbl_count[hit]++;
                tbl_seq[hit]   = seq;
                tbl_known[hit] = tbl_known[hit] | known;
                r.status = ST_UPDATED;
            end
            else
            begin
                r.status = ST_SAME_CYCLE;
            end
            r.count = tbl_count[hit];
            r.known = tbl_known[hit];
        end
        n_removed = 0;
        if (tbl_total > sweep_above)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                // age wraps modulo 2^32
                if (tbl_valid[i] && (seq - tbl_seq[i]) > stale_age)
                begin
                    tbl_valid[i] = 1'b0;
                    tbl_total--;
                    n_removed++;
                end
            end
        end
        r.occ     = 8'(tbl_total);
        r.removed = 8'(n_removed);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Sender: bursts of requests with random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && accepted_n != issued_n)
        begin
            s_tvalid <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            s_tvalid <= 1'b0;
        end
        else if (pending_q.size() > 0)
        begin
            next_req = pending_q.pop_front();
            s_tdata  <= {7'd0, next_req.known, next_req.seq, next_req.id};
            s_tuser  <= next_req.skip;
            s_tvalid <= 1'b1;
            issued_n++;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(0, 12);
                gap_pick = $urandom_range(0, 19);
                if (gap_pick < 12)
                    gap_left = 0;
                else if (gap_pick < 19)
                    gap_left = $urandom_range(1, 5);
                else
                    gap_left = $urandom_range(20, 300);
            end
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall pattern in windows, plus an occasional long hold
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            else
            begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // Monitor: predict on each accepted request, check each result, watch for hangs
    always @(posedge clk)
    begin
        sighting_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_MAX_ENTRIES: lim_entries = cfg_data[7:0];
                    CFG_CLEANUP:     sweep_above = cfg_data[7:0];
                    CFG_KEEP_AGE:    stale_age   = {16'd0, cfg_data};
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                result_q.insert(result_q.size(), track_sighting(s_tdata[31:0], s_tdata[63:32],
                                                                s_tdata[64], s_tuser[0]));
                accepted_n++;
            end
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("appear_count", want.count, m_tdata[31:0]);
                    check_field("ever_known", 32'(want.known), 32'(m_tdata[32]));
                    check_field("occupancy", 32'(want.occ), 32'(m_tdata[40:33]));
                    check_field("removed", 32'(want.removed), 32'(m_tdata[48:41]));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic queue_sighting(logic [31:0] id, logic [31:0] seq, logic known, logic skip);
        sighting_t it;
        it.id = id;
        it.seq = seq;
        it.known = known;
        it.skip = skip;
        pending_q.insert(pending_q.size(), it);
        pushed_n++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (accepted_n != pushed_n || result_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Planning cycles of a few sightings each, drawn from a pool of ids, with some noise
    task automatic run_traffic(int n_items, int pool_n);
        int          left_in_cycle;
        int          r;
        logic [31:0] id;
        id_pool.delete();
        for (int i = 0; i < pool_n; i++)
            id_pool.insert(id_pool.size(), $urandom);
        left_in_cycle = 0;
        @(posedge clk);
        for (int k = 0; k < n_items; k++)
        begin
            if (left_in_cycle == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    plan_seq = $urandom;
                else if (r < 12)
                    plan_seq += $urandom_range(2, 12);
                else
                    plan_seq += 1;
                left_in_cycle = $urandom_range(1, 10);
            end
            left_in_cycle--;
            id = id_pool[$urandom_range(0, id_pool.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < 6)
                queue_sighting($urandom, $urandom, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            else if (r < 12)
                queue_sighting(id, plan_seq, 1'($urandom_range(0, 1)), 1'b1);
            else if (r < 16)
                queue_sighting(id, plan_seq - $urandom_range(1, 8), 1'($urandom_range(0, 1)),
                               1'b0);
            else
                queue_sighting(id, plan_seq, 1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    task automatic run_phase(logic [15:0] max_v, logic [15:0] cleanup_v, logic [15:0] keep_v,
                             int n_items, int pool_n, bit with_hold);
        write_reg(CFG_MAX_ENTRIES, max_v);
        write_reg(CFG_CLEANUP, cleanup_v);
        write_reg(CFG_KEEP_AGE, keep_v);
        run_traffic(n_items, pool_n);
        // block stalls its input while the output is held off
        if (with_hold)
            hold_req = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed sightings on the reset settings
        @(posedge clk);
        queue_sighting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_sighting(32'h0000_0000, 32'd0, 1'b0, 1'b0);
        queue_sighting(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
        queue_sighting(32'h0000_0000, 32'd0, 1'b1, 1'b0);
        queue_sighting(32'h0000_0000, 32'd1, 1'b1, 1'b0);
        queue_sighting(32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0);
        queue_sighting(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_sighting(32'h0000_0000, 32'd0, 1'b0, 1'b0);
        queue_sighting(32'h0000_0000, 32'd5, 1'b0, 1'b1);
        queue_sighting(32'h8000_0001, 32'h7FFF_FFFF, 1'b1, 1'b0);
        wait_drained();

        // Limit above the table depth, no sweep: fill every slot, then drop
        write_reg(CFG_MAX_ENTRIES, 16'hFFC8);
        write_reg(CFG_CLEANUP, 16'hFF80);
        write_reg(CFG_KEEP_AGE, 16'h0000);
        @(posedge clk);
        for (int i = 0; i < 130; i++)
        begin
            fill_ids.insert(fill_ids.size(), {8'(i), 8'hA5, 16'($urandom)});
            queue_sighting(fill_ids[i], 32'd100, 1'($urandom_range(0, 1)), 1'b0);
        end
        wait_drained();

        // Limit zero: nothing inserted, present ids still counted, sweep on every unskipped step
        write_reg(CFG_MAX_ENTRIES, 16'h0000);
        write_reg(CFG_CLEANUP, 16'h0000);
        write_reg(CFG_KEEP_AGE, 16'hFFFF);
        @(posedge clk);
        queue_sighting(32'h1234_5678, 32'd200, 1'b1, 1'b0);
        queue_sighting(fill_ids[0], 32'd200, 1'b1, 1'b0);
        queue_sighting(fill_ids[0], 32'd200, 1'b0, 1'b1);
        queue_sighting(fill_ids[0], 32'd200, 1'b0, 1'b0);
        queue_sighting(fill_ids[1], 32'd100000, 1'b0, 1'b0);
        queue_sighting(fill_ids[1], 32'd100000, 1'b1, 1'b0);
        queue_sighting(32'h1234_5678, 32'd100000, 1'b0, 1'b0);
        queue_sighting(fill_ids[0], 32'd100001, 1'b0, 1'b0);
        wait_drained();

        plan_seq = 32'd1000;
        run_phase(16'd16, 16'd8, 16'd2, 200, 24, 1'b0);
        run_phase(16'd60, 16'd40, 16'd3, 200, 70, 1'b1);
        plan_seq = 32'hFFFF_FFE0;
        run_phase(16'd100, 16'd75, 16'd5, 200, 110, 1'b1);
        run_phase(16'h00FF, 16'd0, 16'd0, 120, 140, 1'b0);
        run_phase(16'd1, 16'd0, 16'hFFFF, 80, 5, 1'b0);
        run_phase(16'd128, 16'd128, 16'hFFFF, 100, 140, 1'b0);

        wait_drained();
        repeat (300) @(posedge clk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
